@@ hw/rtl/uarc_pkg.sv @@
// Shared types and constants for the assistance-record checker.
package uarc_pkg;

  localparam int DATE_W = 25;

  // Byte positions inside one 84-byte record.
  localparam logic [6:0] POS_SUM_FIRST = 7'd2;
  localparam logic [6:0] POS_LEN_LO    = 7'd4;
  localparam logic [6:0] POS_LEN_HI    = 7'd5;
  localparam logic [6:0] POS_KIND      = 7'd6;
  localparam logic [6:0] POS_VERSION   = 7'd7;
  localparam logic [6:0] POS_SAT       = 7'd8;
  localparam logic [6:0] POS_GNSS      = 7'd9;
  localparam logic [6:0] POS_YEAR      = 7'd10;
  localparam logic [6:0] POS_MONTH     = 7'd11;
  localparam logic [6:0] POS_DAY       = 7'd12;
  localparam logic [6:0] POS_SUM_LAST  = 7'd81;
  localparam logic [6:0] POS_CK_A      = 7'd82;
  localparam logic [6:0] POS_CK_B      = 7'd83;

  localparam logic [15:0] LEN_EXPECT = 16'd76;
  localparam logic [11:0] YEAR_BASE  = 12'd2000;
  localparam logic [13:0] YEAR_MUL   = 14'd10000;
  localparam logic [6:0]  MONTH_MUL  = 7'd100;

  localparam logic [DATE_W-1:0] DATE_ALL_ONES = '1;
  localparam logic [DATE_W-1:0] BEGIN_RESET   = 25'd20000101;
  localparam logic [DATE_W-1:0] END_RESET     = 25'd20501231;

  // Register indexes of the configuration port.
  localparam logic [1:0] CFG_FILTER_ENABLE = 2'd0;
  localparam logic [1:0] CFG_RANGE_BEGIN   = 2'd1;
  localparam logic [1:0] CFG_RANGE_END     = 2'd2;

  typedef struct packed {
    logic              filter_enable;
    logic [DATE_W-1:0] range_begin;
    logic [DATE_W-1:0] range_end;
  } cfg_t;

  // Declared high field first so that checksum_ok lands in bit 0.
  typedef struct packed {
    logic [DATE_W-1:0] latest_date;
    logic [DATE_W-1:0] earliest_date;
    logic [7:0]        record_version;
    logic [7:0]        record_kind;
    logic [7:0]        gnss_id;
    logic [7:0]        sat_id;
    logic [DATE_W-1:0] record_date;
    logic              in_range;
    logic              length_ok;
    logic              checksum_ok;
  } res_t;

endpackage

@@ hw/rtl/uarc_cfg_regs.sv @@
// Configuration registers: filter enable and the two date bounds.
module uarc_cfg_regs (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wen,
  input  logic [1:0]             cfg_index,
  input  logic [24:0]            cfg_wdata,
  output uarc_pkg::cfg_t         cfg
);
  import uarc_pkg::*;

  logic              filter_enable_r;
  logic [DATE_W-1:0] range_begin_r;
  logic [DATE_W-1:0] range_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_enable_r <= 1'b0;
      range_begin_r   <= BEGIN_RESET;
      range_end_r     <= END_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        CFG_FILTER_ENABLE: filter_enable_r <= cfg_wdata[0];
        CFG_RANGE_BEGIN:   range_begin_r   <= cfg_wdata;
        CFG_RANGE_END:     range_end_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg.filter_enable = filter_enable_r;
  assign cfg.range_begin   = range_begin_r;
  assign cfg.range_end     = range_end_r;

endmodule

@@ hw/rtl/uarc_accum.sv @@
// Per-byte record tracker: position, running sums, field capture and date window.
module uarc_accum (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  logic [7:0]     rx_byte,
  input  logic           file_start,
  input  uarc_pkg::cfg_t cfg,
  output logic           res_valid,
  output uarc_pkg::res_t res
);
  import uarc_pkg::*;

  logic [6:0]        pos_r, pos_nxt;
  logic [7:0]        sum_a_r, sum_a_nxt;
  logic [7:0]        sum_b_r, sum_b_nxt;
  logic [DATE_W-1:0] min_r, min_nxt;
  logic [DATE_W-1:0] max_r, max_nxt;
  logic [15:0]       len_r;
  logic [7:0]        kind_r, ver_r, sat_r, gnss_r, year_r, month_r, ck_a_r;
  logic [DATE_W-1:0] date_r;

  logic [6:0]        pos;
  logic [7:0]        base_a, base_b, add_a, add_b;
  logic [DATE_W-1:0] base_min, base_max;
  logic              last;
  logic [11:0]       year_full;
  logic [25:0]       year_prod;
  logic [14:0]       month_prod;
  logic [DATE_W-1:0] date_calc;
  logic              swap;
  logic [DATE_W-1:0] lo, hi;

  // A file-start mark makes this byte count as byte 0 of a fresh record.
  always_comb begin
    pos      = file_start ? 7'd0 : pos_r;
    base_a   = file_start ? 8'd0 : sum_a_r;
    base_b   = file_start ? 8'd0 : sum_b_r;
    base_min = file_start ? DATE_ALL_ONES : min_r;
    base_max = file_start ? '0 : max_r;
    last     = (pos == POS_CK_B);
    add_a    = base_a + rx_byte;
    add_b    = base_b + add_a;

    if (last) begin
      pos_nxt   = 7'd0;
      sum_a_nxt = 8'd0;
      sum_b_nxt = 8'd0;
    end else begin
      pos_nxt = pos + 7'd1;
      if (pos >= POS_SUM_FIRST && pos <= POS_SUM_LAST) begin
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
      end else begin
        sum_a_nxt = base_a;
        sum_b_nxt = base_b;
      end
    end

    // The date is built when the day byte arrives, long before the record ends.
    year_full  = YEAR_BASE + {4'b0, year_r};
    year_prod  = {14'b0, year_full} * {12'b0, YEAR_MUL};
    month_prod = {7'b0, month_r} * {8'b0, MONTH_MUL};
    date_calc  = year_prod[DATE_W-1:0] + {10'b0, month_prod} + {17'b0, rx_byte};

    swap = cfg.range_begin > cfg.range_end;
    lo   = swap ? cfg.range_end   : cfg.range_begin;
    hi   = swap ? cfg.range_begin : cfg.range_end;

    min_nxt = base_min;
    max_nxt = base_max;
    if (last) begin
      if (date_r < base_min) min_nxt = date_r;
      if (date_r > base_max) max_nxt = date_r;
    end

    res_valid          = accept && last;
    res.checksum_ok    = (base_a == ck_a_r) && (base_b == rx_byte);
    res.length_ok      = (len_r == LEN_EXPECT);
    res.in_range       = !cfg.filter_enable || (lo <= date_r && date_r <= hi);
    res.record_date    = date_r;
    res.sat_id         = sat_r;
    res.gnss_id        = gnss_r;
    res.record_kind    = kind_r;
    res.record_version = ver_r;
    res.earliest_date  = min_nxt;
    res.latest_date    = max_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= 7'd0;
      sum_a_r <= 8'd0;
      sum_b_r <= 8'd0;
      min_r   <= DATE_ALL_ONES;
      max_r   <= '0;
    end else if (accept) begin
      pos_r   <= pos_nxt;
      sum_a_r <= sum_a_nxt;
      sum_b_r <= sum_b_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      unique case (pos)
        POS_LEN_LO:  len_r[7:0]  <= rx_byte;
        POS_LEN_HI:  len_r[15:8] <= rx_byte;
        POS_KIND:    kind_r      <= rx_byte;
        POS_VERSION: ver_r       <= rx_byte;
        POS_SAT:     sat_r       <= rx_byte;
        POS_GNSS:    gnss_r      <= rx_byte;
        POS_YEAR:    year_r      <= rx_byte;
        POS_MONTH:   month_r     <= rx_byte;
        POS_DAY:     date_r      <= date_calc;
        POS_CK_A:    ck_a_r      <= rx_byte;
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/uarc_out_buf.sv @@
// Two-entry result buffer: output register plus skid slot.
module uarc_out_buf (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  uarc_pkg::res_t push_data,
  output logic           push_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output uarc_pkg::res_t out_data
);
  import uarc_pkg::*;

  logic v0_r, v0_nxt, v1_r, v1_nxt;
  res_t d0_r, d0_nxt, d1_r, d1_nxt;
  logic pop;

  assign pop        = v0_r && out_ready;
  assign push_ready = !v1_r;
  assign out_valid  = v0_r;
  assign out_data   = d0_r;

  always_comb begin
    v0_nxt = v0_r;
    v1_nxt = v1_r;
    d0_nxt = d0_r;
    d1_nxt = d1_r;
    case ({push, pop})
      2'b10: begin
        if (!v0_r) begin
          v0_nxt = 1'b1;
          d0_nxt = push_data;
        end else begin
          v1_nxt = 1'b1;
          d1_nxt = push_data;
        end
      end
      2'b01: begin
        v0_nxt = v1_r;
        v1_nxt = 1'b0;
        d0_nxt = d1_r;
      end
      2'b11: begin
        if (v1_r) begin
          d0_nxt = d1_r;
          d1_nxt = push_data;
        end else begin
          d0_nxt = push_data;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d0_r <= d0_nxt;
    d1_r <= d1_nxt;
  end

endmodule

@@ hw/rtl/ubx_ano_record_checker.sv @@
// Top level of the 84-byte assistance-record checker.
//
//  channel | direction | contents
//  in_     | slave     | one stream byte per request, file-start flag in tuser
//  out_    | master    | one result per complete record
//  cfg_    | write     | filter enable, range begin, range end
//
// One byte is taken every cycle while in_tready is high; the record's result
// is registered into a two-entry output buffer when its last byte is taken.
// The byte tracker updates its registers in the cycle a byte is taken.
// Reset is synchronous and active low and restarts alignment at the next byte.
// in_tready drops only while both buffer entries hold results that wait.
module ubx_ano_record_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,   // [7:0] rx_byte
  input  logic [0:0]    in_tuser,   // [0] file_start
  output logic          out_tvalid,
  input  logic          out_tready,
  // [0] checksum_ok, [1] length_ok, [2] in_range, [27:3] record_date,
  // [35:28] sat_id, [43:36] gnss_id, [51:44] record_kind,
  // [59:52] record_version, [84:60] earliest_date, [109:85] latest_date,
  // [111:110] zero
  output logic [111:0]  out_tdata,
  input  logic          cfg_wen,
  input  logic [1:0]    cfg_index,
  input  logic [24:0]   cfg_wdata
);
  import uarc_pkg::*;

  cfg_t cfg;
  res_t res, buf_data;
  logic res_valid;
  logic accept;
  logic buf_ready;

  assign in_tready = buf_ready;
  assign accept    = in_tvalid && buf_ready;

  uarc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  uarc_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .rx_byte    (in_tdata),
    .file_start (in_tuser[0]),
    .cfg        (cfg),
    .res_valid  (res_valid),
    .res        (res)
  );

  uarc_out_buf u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_data  (res),
    .push_ready (buf_ready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (buf_data)
  );

  assign out_tdata = {2'b00, buf_data};

endmodule
